@@ sv/avt_pkg.sv @@
// ----------------------------------------------------------------------------
// avt_pkg
// Shared constants and types for the affine vector transform.
// ----------------------------------------------------------------------------
package avt_pkg;

    // Default fixed-point format
    localparam int FRACTION_BITS_DEF   = 12;
    localparam int COMPONENT_WIDTH_DEF = 16;

    // Configuration registers are all at most this wide
    localparam int REG_W     = 48;
    localparam int CFG_IDX_W = 3;

    // Vector components and matrix rows per item
    localparam int NUM_LANES = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_FIRST   = 3'd0,
        CFG_ROW_SECOND  = 3'd1,
        CFG_ROW_THIRD   = 3'd2,
        CFG_TRANSLATION = 3'd3,
        CFG_ADD_TRANS   = 3'd4
    } cfg_index_t;

    // Per-lane control from the top level
    typedef struct packed {
        logic load;            // capture products of an accepted item
        logic add_translation; // add the lane's translation component
    } lane_ctrl_t;

endpackage

@@ sv/avt_if.sv @@
// ----------------------------------------------------------------------------
// avt_if
// Valid/ready channels for input vectors and result vectors.
// ----------------------------------------------------------------------------
interface avt_in_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] in_x;
    logic signed [W-1:0] in_y;
    logic signed [W-1:0] in_z;

    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface avt_out_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_x;
    logic signed [W-1:0] out_y;
    logic signed [W-1:0] out_z;

    modport source (output valid, output out_x, output out_y, output out_z, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

@@ sv/avt_lane.sv @@
// ----------------------------------------------------------------------------
// avt_lane
// One matrix row: three registered products, then Q scaling toward zero,
// wrapped row sum and optional translation.
// ----------------------------------------------------------------------------
module avt_lane
    import avt_pkg::*;
#(
    parameter int F    = FRACTION_BITS_DEF,
    parameter int W    = COMPONENT_WIDTH_DEF,
    parameter int LANE = 0
)(
    input  logic                clk,
    input  lane_ctrl_t          ctrl,
    input  logic [REG_W-1:0]    row,
    input  logic [REG_W-1:0]    trans,
    input  logic signed [W-1:0] vec_x,
    input  logic signed [W-1:0] vec_y,
    input  logic signed [W-1:0] vec_z,
    output logic [W-1:0]        sum
);

    // Entries past the register's top read as zero
    localparam int EXT_W = (3 * W > REG_W) ? 3 * W : REG_W;
    localparam logic [2*W-1:0] BIAS = (2*W)'((64'd1 << F) - 64'd1);

    logic [EXT_W-1:0]      row_ext;
    logic [EXT_W-1:0]      trans_ext;
    logic signed [W-1:0]   coef [3];
    logic signed [W-1:0]   vec  [3];
    logic signed [2*W-1:0] prod_reg [3];
    logic signed [2*W-1:0] biased  [3];
    logic signed [2*W-1:0] shifted [3];
    logic [W-1:0]          scaled  [3];
    logic [W-1:0]          trans_c;

    assign row_ext   = EXT_W'(row);
    assign trans_ext = EXT_W'(trans);
    assign trans_c   = trans_ext[LANE*W +: W];

    assign vec[0] = vec_x;
    assign vec[1] = vec_y;
    assign vec[2] = vec_z;

    for (genvar c = 0; c < 3; c++)
    begin : g_col
        assign coef[c] = $signed(row_ext[c*W +: W]);

        // Product register
        always_ff @(posedge clk)
        begin
            if (ctrl.load)
            begin
                prod_reg[c] <= coef[c] * vec[c];
            end
        end

        // Divide by 2^F rounding toward zero: bias negatives before the shift
        assign biased[c]  = prod_reg[c] + (prod_reg[c][2*W-1] ? $signed(BIAS) : '0);
        assign shifted[c] = biased[c] >>> F;
        assign scaled[c]  = shifted[c][W-1:0];
    end

    // Wrapped row sum plus optional translation
    assign sum = scaled[0] + scaled[1] + scaled[2]
               + (ctrl.add_translation ? trans_c : '0);

endmodule

@@ sv/avt_merge.sv @@
// ----------------------------------------------------------------------------
// avt_merge
// Output stage: gathers the three lane sums into one result item and holds
// it until the sink takes it.
// ----------------------------------------------------------------------------
module avt_merge
    import avt_pkg::*;
#(
    parameter int W = COMPONENT_WIDTH_DEF
)(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s1_valid,
    output logic                            s1_ready,
    input  logic [NUM_LANES-1:0][W-1:0]     lane_sum,
    avt_out_if.source                       out_ch
);

    logic         out_valid_reg;
    logic         out_valid_next;
    logic [W-1:0] out_x_reg;
    logic [W-1:0] out_y_reg;
    logic [W-1:0] out_z_reg;
    logic         load;

    // Free when empty or when the held item leaves this cycle
    assign s1_ready = !out_valid_reg || out_ch.ready;
    assign load     = s1_valid && s1_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_ready)
        begin
            out_valid_next = s1_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_x_reg <= lane_sum[0];
            out_y_reg <= lane_sum[1];
            out_z_reg <= lane_sum[2];
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.out_x = $signed(out_x_reg);
    assign out_ch.out_y = $signed(out_y_reg);
    assign out_ch.out_z = $signed(out_z_reg);

endmodule

@@ sv/affine_vector_transform.sv @@
// ----------------------------------------------------------------------------
// affine_vector_transform
// 3x3 fixed-point matrix times vector, with optional translation.
//
//   channel   dir   handshake         payload
//   in_ch     in    valid / ready     in_x, in_y, in_z   (signed, W bits)
//   out_ch    out   valid / ready     out_x, out_y, out_z (signed, W bits)
//   cfg       in    cfg_we            cfg_index, cfg_data (48 bits)
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes the product register, then the output register, before its result is
// valid. Three row lanes run in parallel, each with three multipliers.
// Reset (rst_n low, async) loads the identity matrix, zero translation and
// translation enabled, and empties the pipeline.
// A stalled output holds its item; the product stage still refills, so input
// stops only when both stages are full.
// ----------------------------------------------------------------------------
module affine_vector_transform
    import avt_pkg::*;
#(
    parameter int FRACTION_BITS   = FRACTION_BITS_DEF,
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [REG_W-1:0]      cfg_data,
    avt_in_if.sink                in_ch,
    avt_out_if.source             out_ch
);

    localparam int W = COMPONENT_WIDTH;
    localparam int F = FRACTION_BITS;
    localparam logic [127:0] ONE = 128'd1;
    localparam logic [REG_W-1:0] ROW0_RST = REG_W'(ONE << F);
    localparam logic [REG_W-1:0] ROW1_RST = REG_W'(ONE << (F + W));
    localparam logic [REG_W-1:0] ROW2_RST = REG_W'(ONE << (F + 2 * W));

    logic [REG_W-1:0]            row_reg [NUM_LANES];
    logic [REG_W-1:0]            trans_reg;
    logic                        add_trans_reg;
    logic                        v1_reg;
    logic                        v1_next;
    logic                        s1_ready;
    logic                        accept;
    lane_ctrl_t                  lane_ctrl;
    logic [NUM_LANES-1:0][W-1:0] lane_sum;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0]    <= ROW0_RST;
            row_reg[1]    <= ROW1_RST;
            row_reg[2]    <= ROW2_RST;
            trans_reg     <= '0;
            add_trans_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROW_FIRST:   row_reg[0]    <= cfg_data;
                CFG_ROW_SECOND:  row_reg[1]    <= cfg_data;
                CFG_ROW_THIRD:   row_reg[2]    <= cfg_data;
                CFG_TRANSLATION: trans_reg     <= cfg_data;
                CFG_ADD_TRANS:   add_trans_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Product stage occupancy
    assign in_ch.ready = !v1_reg || s1_ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        v1_next = v1_reg;
        if (in_ch.ready)
        begin
            v1_next = in_ch.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
        end
    end

    assign lane_ctrl.load            = accept;
    assign lane_ctrl.add_translation = add_trans_reg;

    // One lane per matrix row
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        avt_lane #(
            .F    (F),
            .W    (W),
            .LANE (l)
        ) u_lane (
            .clk   (clk),
            .ctrl  (lane_ctrl),
            .row   (row_reg[l]),
            .trans (trans_reg),
            .vec_x (in_ch.in_x),
            .vec_y (in_ch.in_y),
            .vec_z (in_ch.in_z),
            .sum   (lane_sum[l])
        );
    end

    // Gather lanes into the result item
    avt_merge #(
        .W (W)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (v1_reg),
        .s1_ready (s1_ready),
        .lane_sum (lane_sum),
        .out_ch   (out_ch)
    );

endmodule
